// File: rtl/rv32s_pkg.sv
package rv32s_pkg;

  // Major opcodes of the supported subset
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;

  // funct3 / funct7 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_BU   = 3'd4;
  localparam logic [2:0] F3_BYTE = 3'd0;
  localparam logic [6:0] F7_ADD  = 7'h00;

  localparam logic [31:0] LUI_MASK  = 32'hFFFF_F000;
  localparam logic [31:0] JALR_MASK = 32'hFFFF_FFFE;

  // Item kind carried in the opcode field of an input transaction
  localparam logic ITEM_PRELOAD = 1'b1;

  typedef enum logic [3:0] {
    INS_ADDI,
    INS_JALR,
    INS_ADD,
    INS_LUI,
    INS_LW,
    INS_SW,
    INS_LBU,
    INS_SB,
    INS_PRELOAD,
    INS_UNSUP
  } instr_e;

  typedef struct packed {
    logic        opcode;
    logic [31:0] instr_word;
    logic [15:0] preload_addr;
    logic [7:0]  preload_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        store_done;
    logic [15:0] store_addr;
    logic [31:0] store_data;
    logic        store_is_word;
    logic        unsupported;
  } result_t;

  // Data memory access control
  typedef struct packed {
    logic rd;
    logic wr;
    logic word;
  } dmem_ctl_t;

  function automatic instr_e decode(input logic opcode, input logic [31:0] w);
    instr_e     cls;
    logic [2:0] f3;
    cls = INS_UNSUP;
    f3  = w[14:12];
    if (opcode == ITEM_PRELOAD) begin
      cls = INS_PRELOAD;
    end else begin
      unique case (w[6:0])
        OPC_OP_IMM: if (f3 == F3_ADD) cls = INS_ADDI;
        OPC_JALR:   if (f3 == F3_ADD) cls = INS_JALR;
        OPC_OP:     if (f3 == F3_ADD && w[31:25] == F7_ADD) cls = INS_ADD;
        OPC_LUI:    cls = INS_LUI;
        OPC_LOAD: begin
          if (f3 == F3_WORD) cls = INS_LW;
          else if (f3 == F3_BU) cls = INS_LBU;
        end
        OPC_STORE: begin
          if (f3 == F3_WORD) cls = INS_SW;
          else if (f3 == F3_BYTE) cls = INS_SB;
        end
        default: cls = INS_UNSUP;
      endcase
    end
    return cls;
  endfunction

endpackage

// File: rtl/rv32s_chan_if.sv
interface rv32s_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/rv32_subset_instruction_step_unit.sv
// Channel  Dir  Payload   Transfer
// in_i     in   item_t    valid & ready: execute an instruction or preload a byte
// out_o    out  result_t  valid & ready: one result per input transaction
//
// Throughput is one transaction per clock while out_o accepts; the pipeline is
// accept/register read, execute/data memory access, writeback, output register
// (out_o is driven from the output register). Load data and register results are
// forwarded to the next instruction. Reset clears pc and all registers (valid
// bits); data memory holds no reset value. When out_o stalls, the output register,
// writeback and execute stages fill in turn and then in_i.ready drops.
module rv32_subset_instruction_step_unit #(
  parameter int unsigned DMEM_ADDR_BITS = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  rv32s_chan_if.sink   in_i,
  rv32s_chan_if.source out_o
);
  import rv32s_pkg::*;

  // Execute stage
  logic        s1_valid_q;
  item_t       s1_item_q;
  logic        s1_adv;
  instr_e      s1_cls;
  logic [31:0] s1_w;
  logic [4:0]  s1_rd;
  logic [4:0]  s1_rs1;
  logic [4:0]  s1_rs2;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] add_b;
  logic [31:0] sum;
  logic [31:0] pc_q;
  logic [31:0] pc_plus4;
  logic        has_rd;
  logic [31:0] val;
  result_t     s1_res;

  // Writeback stage
  logic        s2_valid_q;
  result_t     s2_res_q;
  instr_e      s2_cls_q;
  logic        s2_ret;
  logic [31:0] s2_val;

  // Output register
  logic        out_valid_q;
  result_t     out_q;
  result_t     out_d;

  // Memory ports
  logic        accept;
  logic [31:0] rf_rdata_a;
  logic [31:0] rf_rdata_b;
  logic        rf_we;
  dmem_ctl_t   dm_ctl;
  logic [DMEM_ADDR_BITS-1:0] dm_addr;
  logic [31:0] dm_wdata;
  logic [31:0] dm_rdata;

  // Handshake and stage advance
  assign s2_ret   = s2_valid_q && (!out_valid_q || out_o.ready);
  assign s1_adv   = s1_valid_q && (!s2_valid_q || s2_ret);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign accept   = in_i.valid && in_i.ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  rv32s_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .raddr_a_i (in_i.payload.instr_word[19:15]),
    .raddr_b_i (in_i.payload.instr_word[24:20]),
    .we_i      (rf_we),
    .waddr_i   (s2_res_q.reg_index),
    .wdata_i   (s2_val),
    .rdata_a_o (rf_rdata_a),
    .rdata_b_o (rf_rdata_b)
  );

  rv32s_dmem #(
    .AddrBits (DMEM_ADDR_BITS)
  ) u_dmem (
    .clk_i   (clk_i),
    .en_i    (s1_adv),
    .ctl_i   (dm_ctl),
    .addr_i  (dm_addr),
    .wdata_i (dm_wdata),
    .rdata_o (dm_rdata)
  );

  // Execute stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_i.payload;
    end
  end

  // Decode and operand selection with forwarding from writeback
  assign s1_w     = s1_item_q.instr_word;
  assign s1_cls   = decode(s1_item_q.opcode, s1_w);
  assign s1_rd    = s1_w[11:7];
  assign s1_rs1   = s1_w[19:15];
  assign s1_rs2   = s1_w[24:20];
  assign imm_i    = {{20{s1_w[31]}}, s1_w[31:20]};
  assign imm_s    = {{20{s1_w[31]}}, s1_w[31:25], s1_w[11:7]};
  assign pc_plus4 = pc_q + 32'd4;

  always_comb begin
    op_a = rf_rdata_a;
    op_b = rf_rdata_b;
    if (s2_valid_q && s2_res_q.reg_written && s2_res_q.reg_index == s1_rs1) op_a = s2_val;
    if (s2_valid_q && s2_res_q.reg_written && s2_res_q.reg_index == s1_rs2) op_b = s2_val;
  end

  // Shared adder: ALU result, jump target and memory address
  always_comb begin
    if (s1_cls == INS_ADD) add_b = op_b;
    else if (s1_cls inside {INS_SW, INS_SB}) add_b = imm_s;
    else add_b = imm_i;
  end
  assign sum = op_a + add_b;

  // Build the result and the memory request
  always_comb begin
    s1_res           = '0;
    s1_res.next_pc   = pc_plus4;
    val              = '0;
    dm_ctl           = '0;
    dm_addr          = DMEM_ADDR_BITS'(sum);
    dm_wdata         = '0;
    has_rd           = s1_cls inside {INS_ADDI, INS_JALR, INS_ADD, INS_LUI, INS_LW, INS_LBU};
    unique case (s1_cls)
      INS_ADDI, INS_ADD: val = sum;
      INS_JALR: begin
        val            = pc_plus4;
        s1_res.next_pc = sum & JALR_MASK;
      end
      INS_LUI: val = s1_w & LUI_MASK;
      INS_LW: begin
        dm_ctl.rd   = 1'b1;
        dm_ctl.word = 1'b1;
      end
      INS_LBU: dm_ctl.rd = 1'b1;
      INS_SW: begin
        dm_ctl.wr   = 1'b1;
        dm_ctl.word = 1'b1;
        dm_wdata    = op_b;
      end
      INS_SB: begin
        dm_ctl.wr = 1'b1;
        dm_wdata  = {24'b0, op_b[7:0]};
      end
      INS_PRELOAD: begin
        s1_res.next_pc = pc_q;
        dm_ctl.wr      = 1'b1;
        dm_addr        = DMEM_ADDR_BITS'(s1_item_q.preload_addr);
        dm_wdata       = {24'b0, s1_item_q.preload_byte};
      end
      INS_UNSUP: s1_res.unsupported = 1'b1;
      default:   s1_res.unsupported = 1'b1;
    endcase
    s1_res.reg_written   = has_rd && s1_rd != 5'd0;
    s1_res.reg_index     = has_rd ? s1_rd : 5'd0;
    s1_res.reg_value     = s1_res.reg_written ? val : 32'd0;
    s1_res.store_done    = dm_ctl.wr;
    s1_res.store_addr    = dm_ctl.wr ? 16'(dm_addr) : 16'd0;
    s1_res.store_data    = dm_wdata;
    s1_res.store_is_word = dm_ctl.wr && dm_ctl.word;
  end

  // Advance pc as each item leaves execute
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (s1_adv) begin
      pc_q <= s1_res.next_pc;
    end
  end

  // Writeback stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_q <= 1'b1;
    end else if (s2_ret) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_res_q <= s1_res;
      s2_cls_q <= s1_cls;
    end
  end

  // Merge load data
  always_comb begin
    s2_val = s2_res_q.reg_value;
    if (s2_cls_q == INS_LW) s2_val = dm_rdata;
    else if (s2_cls_q == INS_LBU) s2_val = {24'b0, dm_rdata[7:0]};
  end

  assign rf_we = s2_ret && s2_res_q.reg_written;

  always_comb begin
    out_d           = s2_res_q;
    out_d.reg_value = s2_res_q.reg_written ? s2_val : 32'd0;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ret) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ret) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_pc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(pc_q))
    else $error("pc moved without an instruction leaving execute");

  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> s2_res_q.reg_index != 5'd0)
    else $error("register file write to x0");

  a_dmem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && dm_ctl.rd |-> !dm_ctl.wr)
    else $error("data memory read and write in one access");

  a_unsup_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.unsupported |->
      !out_o.payload.reg_written && !out_o.payload.store_done)
    else $error("unsupported instruction changed state");

  a_preload_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_cls == INS_PRELOAD |=> $stable(pc_q))
    else $error("preload changed pc");
`endif
endmodule

// File: rtl/rv32s_regfile.sv
module rv32s_regfile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rd_en_i,
  input  logic [4:0]  raddr_a_i,
  input  logic [4:0]  raddr_b_i,
  input  logic        we_i,
  input  logic [4:0]  waddr_i,
  input  logic [31:0] wdata_i,
  output logic [31:0] rdata_a_o,
  output logic [31:0] rdata_b_o
);
  logic [31:0] mem [32];
  logic [31:0] vld_q;
  logic [31:0] rdata_a_q;
  logic [31:0] rdata_b_q;

  // Track written entries; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  // Write port, two registered read ports with same-edge write bypass
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      if (we_i && waddr_i == raddr_a_i) rdata_a_q <= wdata_i;
      else if (vld_q[raddr_a_i]) rdata_a_q <= mem[raddr_a_i];
      else rdata_a_q <= '0;
      if (we_i && waddr_i == raddr_b_i) rdata_b_q <= wdata_i;
      else if (vld_q[raddr_b_i]) rdata_b_q <= mem[raddr_b_i];
      else rdata_b_q <= '0;
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;
endmodule

// File: rtl/rv32s_dmem.sv
module rv32s_dmem #(
  parameter int unsigned AddrBits = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  rv32s_pkg::dmem_ctl_t  ctl_i,
  input  logic [AddrBits-1:0]   addr_i,
  input  logic [31:0]           wdata_i,
  output logic [31:0]           rdata_o
);
  import rv32s_pkg::*;

  localparam int unsigned RowBits = AddrBits - 2;
  localparam int unsigned Rows    = 1 << RowBits;

  logic [1:0]         off;
  logic [RowBits-1:0] base_row;
  logic [1:0]         off_q;
  logic [3:0][7:0]    bank_rdata;

  assign off      = addr_i[1:0];
  assign base_row = addr_i[AddrBits-1:2];

  // Remember the byte offset of a load for lane alignment
  always_ff @(posedge clk_i) begin
    if (en_i && ctl_i.rd) begin
      off_q <= off;
    end
  end

  // Four byte banks interleaved on the low address bits
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]         mem [Rows];
    logic [1:0]         lane;
    logic [RowBits-1:0] row;
    logic               we;
    logic [7:0]         wbyte;
    logic [7:0]         rdata_q;

    always_comb begin
      lane  = 2'(k) - off;
      row   = base_row + RowBits'((2'(k) < off) ? 1 : 0);
      we    = en_i && ctl_i.wr && (ctl_i.word || lane == 2'd0);
      wbyte = wdata_i[{lane, 3'b000} +: 8];
    end

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[row] <= wbyte;
      end
      if (en_i && ctl_i.rd) begin
        rdata_q <= mem[row];
      end
    end

    assign bank_rdata[k] = rdata_q;
  end

  // Rotate bank outputs into little-endian order
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rdata_o[i*8 +: 8] = bank_rdata[2'(off_q + 2'(i))];
    end
  end
endmodule
